// File: hdl/edfb_pkg.sv
// Shared constants, types and coefficient tables for the depth fog blend block.
package edfb_pkg;

   localparam int CHAN_BITS       = 8;
   localparam int DEPTH_FRAC_BITS = 8;
   localparam int DEPTH_BITS      = 16 + DEPTH_FRAC_BITS;
   localparam int DENS_BITS       = 17;
   localparam int K_BITS          = 17;
   localparam int LOG_BITS        = 21;
   localparam int PROD_BITS       = DEPTH_BITS + LOG_BITS;
   localparam int E_BITS          = PROD_BITS + 1 - DEPTH_FRAC_BITS;
   localparam int EXP_STEPS       = 16;
   localparam int R_BITS          = 31;
   localparam int COEF_BITS       = 30;
   localparam int RPROD_BITS      = R_BITS + COEF_BITS;
   localparam int PIPE_LAT        = 2 + 2 * EXP_STEPS + 3;

   localparam logic [K_BITS-1:0]    ONE_Q16 = K_BITS'(65536);
   localparam logic [R_BITS-1:0]    ONE_Q30 = R_BITS'(1) << 30;
   localparam logic [PROD_BITS:0]   E_HALF  = (DEPTH_FRAC_BITS > 0) ?
                                    ((PROD_BITS + 1)'(1) << (DEPTH_FRAC_BITS - 1)) : '0;

   // CSR word indexes
   localparam logic [1:0] REG_DENSITY = 2'd0;
   localparam logic [1:0] REG_RED     = 2'd1;
   localparam logic [1:0] REG_GREEN   = 2'd2;
   localparam logic [1:0] REG_BLUE    = 2'd3;

   typedef struct packed {
      logic [CHAN_BITS-1:0] red;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] blue;
      logic                 frame_end;
      logic                 k_one;
      logic                 k_zero;
      logic [4:0]           ipart;
      logic [15:0]          frac;
      logic [R_BITS-1:0]    r;
   } pix_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bitv;
      v    = v_arg;
      res  = '0;
      bitv = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // c_1 = 2^-(1/2) in Q.30, each next one the square root of the last
   function automatic logic [COEF_BITS-1:0] exp_coef(input int n);
      logic [63:0] c;
      c = isqrt64(64'd1 << 59);
      for (int i = 1; i < n; i++) begin
         c = isqrt64(c << 30);
      end
      return COEF_BITS'(c);
   endfunction

   localparam logic [COEF_BITS-1:0] EXP_COEF [EXP_STEPS] = '{
      exp_coef(1),  exp_coef(2),  exp_coef(3),  exp_coef(4),
      exp_coef(5),  exp_coef(6),  exp_coef(7),  exp_coef(8),
      exp_coef(9),  exp_coef(10), exp_coef(11), exp_coef(12),
      exp_coef(13), exp_coef(14), exp_coef(15), exp_coef(16)
   };

endpackage

// File: hdl/edfb_log_unit.sv
// Iterative -log2(1 - density) unit, rerun after every density write.
module edfb_log_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic [edfb_pkg::DENS_BITS-1:0]     density,
   output logic                               busy,
   output logic [edfb_pkg::LOG_BITS-1:0]      neg_log
);

   typedef enum logic [1:0] {ST_IDLE, ST_NORM, ST_SQ, ST_ADJ} state_type;

   state_type                         state_ff, state_in;
   logic [15:0]                       x_ff, x_in;
   logic [3:0]                        p_ff, p_in;
   logic [edfb_pkg::R_BITS-1:0]       m_ff, m_in;
   logic [61:0]                       sq_ff, sq_in;
   logic [15:0]                       frac_ff, frac_in;
   logic [3:0]                        cnt_ff, cnt_in;
   logic [edfb_pkg::LOG_BITS-1:0]     nlog_ff, nlog_in;
   logic [15:0]                       x_sat;
   logic [31:0]                       mm;
   logic                              fbit;

   assign x_sat = (density >= edfb_pkg::ONE_Q16) ? 16'd0 : 16'(edfb_pkg::ONE_Q16 - density);
   assign mm    = sq_ff[61:30];
   assign fbit  = mm[31];

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      sq_in    = sq_ff;
      frac_in  = frac_ff;
      cnt_in   = cnt_ff;
      nlog_in  = nlog_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               x_in     = x_sat;
               frac_in  = '0;
               cnt_in   = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            p_in = '0;
            for (int i = 0; i < 16; i++) begin
               if (x_ff[i]) p_in = 4'(i);
            end
            m_in     = edfb_pkg::R_BITS'({15'd0, x_ff} << (5'd30 - {1'b0, p_in}));
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sq_in    = 62'(m_ff) * 62'(m_ff);
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            m_in    = fbit ? mm[31:1] : mm[30:0];
            frac_in = {frac_ff[14:0], fbit};
            cnt_in  = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               nlog_in  = {5'(5'd16 - {1'b0, p_ff}), 16'd0} - edfb_pkg::LOG_BITS'(frac_in);
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SQ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         nlog_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         nlog_ff  <= nlog_in;
      end
      x_ff    <= x_in;
      p_ff    <= p_in;
      m_ff    <= m_in;
      sq_ff   <= sq_in;
      frac_ff <= frac_in;
   end

   assign busy    = (state_ff != ST_IDLE);
   assign neg_log = nlog_ff;

`ifndef SYNTHESIS
   a_mant_norm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ && x_ff != 16'd0) |-> m_ff[30])
      else $error("log mantissa left normal range");
`endif

endmodule

// File: hdl/edfb_exp_step.sv
// One conditional multiply of the 2^-f product chain, two register stages.
module edfb_exp_step (
   input  logic                clock,
   input  logic                reset,
   input  logic [3:0]          step_idx,
   input  logic                in_valid,
   input  edfb_pkg::pix_type   in_pix,
   output logic                out_valid,
   output edfb_pkg::pix_type   out_pix
);

   logic                                 mv_ff, mv_in;
   edfb_pkg::pix_type                    mp_ff;
   logic [edfb_pkg::RPROD_BITS-1:0]      prod_ff, prod_in;
   logic                                 ov_ff;
   edfb_pkg::pix_type                    op_ff, op_in;
   logic [edfb_pkg::RPROD_BITS:0]        rsum;
   logic                                 take;

   // step n handles the fraction bit of weight 2^-(n+1)
   assign take  = in_pix.frac[4'd15 - step_idx];
   assign mv_in = in_valid;

   always_comb begin
      if (take) begin
         prod_in = edfb_pkg::RPROD_BITS'(in_pix.r) *
                   edfb_pkg::RPROD_BITS'(edfb_pkg::EXP_COEF[step_idx]);
      end else begin
         prod_in = {in_pix.r, 30'd0};
      end
   end

   assign rsum = {1'b0, prod_ff} + (edfb_pkg::RPROD_BITS + 1)'(1 << 29);

   always_comb begin
      op_in   = mp_ff;
      op_in.r = rsum[30 +: edfb_pkg::R_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else begin
         mv_ff <= mv_in;
         ov_ff <= mv_ff;
      end
      mp_ff   <= in_pix;
      prod_ff <= prod_in;
      op_ff   <= op_in;
   end

   assign out_valid = ov_ff;
   assign out_pix   = op_ff;

endmodule

// File: hdl/edfb_blend.sv
// Fog factor scaling and per-channel blend, three register stages.
module edfb_blend (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   input  edfb_pkg::pix_type                in_pix,
   input  logic [edfb_pkg::CHAN_BITS-1:0]   fog_red,
   input  logic [edfb_pkg::CHAN_BITS-1:0]   fog_green,
   input  logic [edfb_pkg::CHAN_BITS-1:0]   fog_blue,
   output logic                             out_valid,
   output logic [edfb_pkg::CHAN_BITS-1:0]   out_red,
   output logic [edfb_pkg::CHAN_BITS-1:0]   out_green,
   output logic [edfb_pkg::CHAN_BITS-1:0]   out_blue,
   output logic                             out_frame_end
);

   localparam int PW = edfb_pkg::CHAN_BITS + edfb_pkg::K_BITS;

   // stage 1: k
   logic                              v1_ff;
   logic [edfb_pkg::K_BITS-1:0]       k_ff, k_in;
   logic [3*edfb_pkg::CHAN_BITS-1:0]  c1_ff;
   logic                              fe1_ff;
   logic [31:0]                       rnd;
   logic [31:0]                       shifted;

   // stage 2: products
   logic                              v2_ff;
   logic [PW-1:0]                     pc_ff [3];
   logic [PW-1:0]                     pf_ff [3];
   logic [PW-1:0]                     pc_in [3];
   logic [PW-1:0]                     pf_in [3];
   logic                              fe2_ff;
   logic [edfb_pkg::K_BITS-1:0]       kinv;

   // stage 3: outputs
   logic                              v3_ff;
   logic [edfb_pkg::CHAN_BITS-1:0]    o_ff [3];
   logic [edfb_pkg::CHAN_BITS-1:0]    o_in [3];
   logic                              fe3_ff;
   logic [PW:0]                       s [3];
   logic [edfb_pkg::CHAN_BITS-1:0]    fogc [3];

   assign rnd     = 32'(in_pix.r) + (32'd1 << (6'd13 + {1'b0, in_pix.ipart}));
   assign shifted = rnd >> (6'd14 + {1'b0, in_pix.ipart});

   always_comb begin
      if (in_pix.k_one) begin
         k_in = edfb_pkg::ONE_Q16;
      end else if (in_pix.k_zero) begin
         k_in = '0;
      end else begin
         k_in = shifted[edfb_pkg::K_BITS-1:0];
      end
   end

   assign kinv    = edfb_pkg::ONE_Q16 - k_ff;
   assign fogc[0] = fog_red;
   assign fogc[1] = fog_green;
   assign fogc[2] = fog_blue;

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         pc_in[ch] = PW'(c1_ff[(2 - ch) * edfb_pkg::CHAN_BITS +: edfb_pkg::CHAN_BITS]) *
                     PW'(k_ff);
         pf_in[ch] = PW'(fogc[ch]) * PW'(kinv);
         s[ch]     = {1'b0, pc_ff[ch]} + {1'b0, pf_ff[ch]} + (PW + 1)'(32768);
         o_in[ch]  = s[ch][16 +: edfb_pkg::CHAN_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      k_ff   <= k_in;
      c1_ff  <= {in_pix.red, in_pix.green, in_pix.blue};
      fe1_ff <= in_pix.frame_end;
      fe2_ff <= fe1_ff;
      fe3_ff <= fe2_ff;
      for (int ch = 0; ch < 3; ch++) begin
         pc_ff[ch] <= pc_in[ch];
         pf_ff[ch] <= pf_in[ch];
         o_ff[ch]  <= o_in[ch];
      end
   end

   assign out_valid     = v3_ff;
   assign out_red       = o_ff[0];
   assign out_green     = o_ff[1];
   assign out_blue      = o_ff[2];
   assign out_frame_end = fe3_ff;

`ifndef SYNTHESIS
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (k_ff <= edfb_pkg::ONE_Q16))
      else $error("fog factor above one");
`endif

endmodule

// File: hdl/exponential_depth_fog_blend_top.sv
// Top level of the exponential depth fog blend: CSRs, depth scaling and pipeline.
//
// Usage:
//  - Pixel words enter on req_* when start is high and busy is low. One pixel
//    can be accepted every clock; the pipeline never backs up on its own.
//  - Each pixel gives one word on rsp_* after the depth, chain and blend
//    registers, marked by rsp_valid for a single cycle. Order is preserved.
//  - Throughput is one pixel per clock while busy is low. Depth x log, exponent
//    rounding, sixteen two-stage 2^-f multiply steps and the blend set the latency.
//  - CSRs (APB style, pready tied high): density at 0x0, fog red/green/blue at
//    0x4/0x8/0xC. Write only while no pixels are in flight.
//  - A density write starts the log2 unit: busy stays high through normalize
//    and then 16 square/adjust pairs, and no pixel is taken meanwhile.
//  - Reset clears all CSRs (density 0 means no fog) and empties the pipeline.
//  - The receiver cannot stall: rsp words must be taken when rsp_valid is high.
module exponential_depth_fog_blend_top (
   input  logic                              clock,
   input  logic                              reset,
   // pixel in
   input  logic                              start,
   output logic                              busy,
   input  logic [edfb_pkg::CHAN_BITS-1:0]    req_pixel_red,
   input  logic [edfb_pkg::CHAN_BITS-1:0]    req_pixel_green,
   input  logic [edfb_pkg::CHAN_BITS-1:0]    req_pixel_blue,
   input  logic [edfb_pkg::DEPTH_BITS-1:0]   req_pixel_depth,
   input  logic                              req_frame_end,
   // pixel out
   output logic                              rsp_valid,
   output logic [edfb_pkg::CHAN_BITS-1:0]    rsp_fogged_red,
   output logic [edfb_pkg::CHAN_BITS-1:0]    rsp_fogged_green,
   output logic [edfb_pkg::CHAN_BITS-1:0]    rsp_fogged_blue,
   output logic                              rsp_frame_end_out,
   // CSR port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [3:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   // ---------------- CSRs ----------------
   logic [edfb_pkg::DENS_BITS-1:0]  density_ff, density_in;
   logic [edfb_pkg::CHAN_BITS-1:0]  fog_red_ff, fog_red_in;
   logic [edfb_pkg::CHAN_BITS-1:0]  fog_green_ff, fog_green_in;
   logic [edfb_pkg::CHAN_BITS-1:0]  fog_blue_ff, fog_blue_in;
   logic                            csr_wr;
   logic [1:0]                      csr_idx;
   logic                            dens_go;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[3:2];
   assign dens_go = csr_wr && (csr_idx == edfb_pkg::REG_DENSITY);

   always_comb begin
      density_in   = density_ff;
      fog_red_in   = fog_red_ff;
      fog_green_in = fog_green_ff;
      fog_blue_in  = fog_blue_ff;
      if (csr_wr) begin
         case (csr_idx)
            edfb_pkg::REG_DENSITY: density_in   = pwdata[edfb_pkg::DENS_BITS-1:0];
            edfb_pkg::REG_RED:     fog_red_in   = pwdata[edfb_pkg::CHAN_BITS-1:0];
            edfb_pkg::REG_GREEN:   fog_green_in = pwdata[edfb_pkg::CHAN_BITS-1:0];
            edfb_pkg::REG_BLUE:    fog_blue_in  = pwdata[edfb_pkg::CHAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         edfb_pkg::REG_DENSITY: prdata = 32'(density_ff);
         edfb_pkg::REG_RED:     prdata = 32'(fog_red_ff);
         edfb_pkg::REG_GREEN:   prdata = 32'(fog_green_ff);
         edfb_pkg::REG_BLUE:    prdata = 32'(fog_blue_ff);
         default:               prdata = '0;
      endcase
   end

   // ---------------- log2 of (1 - density) ----------------
   logic [edfb_pkg::LOG_BITS-1:0]   neg_log;

   edfb_log_unit u_log (
      .clock   (clock),
      .reset   (reset),
      .go      (dens_go),
      .density (density_in),
      .busy    (busy),
      .neg_log (neg_log)
   );

   // ---------------- stage 1: depth * L ----------------
   logic                            accept;
   logic                            v1_ff;
   edfb_pkg::pix_type               p1_ff, p1_in;
   logic [edfb_pkg::PROD_BITS-1:0]  prod_ff, prod_in;
   logic                            dens_zero;
   logic                            dens_full;
   logic                            depth_zero;

   assign accept     = start && !busy;
   assign dens_zero  = (density_ff == '0);
   assign dens_full  = (density_ff >= edfb_pkg::ONE_Q16);
   assign depth_zero = (req_pixel_depth == '0);
   assign prod_in    = edfb_pkg::PROD_BITS'(req_pixel_depth) * edfb_pkg::PROD_BITS'(neg_log);

   always_comb begin
      p1_in           = '0;
      p1_in.red       = req_pixel_red;
      p1_in.green     = req_pixel_green;
      p1_in.blue      = req_pixel_blue;
      p1_in.frame_end = req_frame_end;
      p1_in.k_one     = depth_zero || dens_zero;
      p1_in.k_zero    = dens_full;
   end

   // ---------------- stage 2: round exponent, split I and f ----------------
   logic                            v2_ff;
   edfb_pkg::pix_type               p2_ff, p2_in;
   logic [edfb_pkg::PROD_BITS:0]    esum;
   logic [edfb_pkg::E_BITS-1:0]     expo;
   logic                            deep;

   assign esum = {1'b0, prod_ff} + edfb_pkg::E_HALF;
   assign expo = esum[edfb_pkg::PROD_BITS:edfb_pkg::DEPTH_FRAC_BITS];
   assign deep = (expo[edfb_pkg::E_BITS-1:16] >= (edfb_pkg::E_BITS - 16)'(17));

   always_comb begin
      p2_in        = p1_ff;
      p2_in.k_zero = p1_ff.k_zero || deep;
      p2_in.ipart  = expo[20:16];
      p2_in.frac   = expo[15:0];
      p2_in.r      = edfb_pkg::ONE_Q30;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         density_ff   <= '0;
         fog_red_ff   <= '0;
         fog_green_ff <= '0;
         fog_blue_ff  <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         density_ff   <= density_in;
         fog_red_ff   <= fog_red_in;
         fog_green_ff <= fog_green_in;
         fog_blue_ff  <= fog_blue_in;
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
      end
      p1_ff   <= p1_in;
      prod_ff <= prod_in;
      p2_ff   <= p2_in;
   end

   // ---------------- 2^-f product chain ----------------
   logic                chain_v [edfb_pkg::EXP_STEPS + 1];
   edfb_pkg::pix_type   chain_p [edfb_pkg::EXP_STEPS + 1];

   assign chain_v[0] = v2_ff;
   assign chain_p[0] = p2_ff;

   for (genvar g = 0; g < edfb_pkg::EXP_STEPS; g++) begin : g_exp
      edfb_exp_step u_step (
         .clock     (clock),
         .reset     (reset),
         .step_idx  (4'(g)),
         .in_valid  (chain_v[g]),
         .in_pix    (chain_p[g]),
         .out_valid (chain_v[g + 1]),
         .out_pix   (chain_p[g + 1])
      );
   end

   // ---------------- scale and blend ----------------
   edfb_blend u_blend (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (chain_v[edfb_pkg::EXP_STEPS]),
      .in_pix        (chain_p[edfb_pkg::EXP_STEPS]),
      .fog_red       (fog_red_ff),
      .fog_green     (fog_green_ff),
      .fog_blue      (fog_blue_ff),
      .out_valid     (rsp_valid),
      .out_red       (rsp_fogged_red),
      .out_green     (rsp_fogged_green),
      .out_blue      (rsp_fogged_blue),
      .out_frame_end (rsp_frame_end_out)
   );

`ifndef SYNTHESIS
   a_lat: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(edfb_pkg::PIPE_LAT) rsp_valid)
      else $error("pixel word did not come out at the pipeline latency");
   a_log_busy: assert property (@(posedge clock) disable iff (reset)
      dens_go |=> busy)
      else $error("density write did not start the log unit");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      busy |=> !v1_ff)
      else $error("pixel entered while log unit was running");
`endif

endmodule
